// File: hw/rtl/pfc_pkg.sv
// Shared types, constants and helper functions for the Playfair digram cipher unit.
package pfc_pkg;

  localparam int QUEUE_DEPTH_DEF = 4;
  localparam int SIDE            = 5;
  localparam int CELLS           = SIDE * SIDE;
  localparam int CELL_W          = 5;
  localparam int CFG_DATA_W      = 60;
  localparam int CFG_INDEX_W     = 2;

  typedef logic [CELL_W-1:0]             code_t;
  typedef logic [2:0]                    rc_t;
  typedef logic [CELLS-1:0][CELL_W-1:0]  square_t;

  localparam code_t LETTER_X = 5'd23;
  localparam code_t LETTER_J = 5'd9;
  localparam code_t LETTER_I = 5'd8;

  localparam logic [7:0] ASCII_UPPER_A = 8'h41;
  localparam logic [7:0] ASCII_UPPER_Z = 8'h5A;
  localparam logic [7:0] ASCII_LOWER_A = 8'h61;
  localparam logic [7:0] ASCII_LOWER_Z = 8'h7A;
  localparam logic [6:0] ASCII_A7      = 7'h41;

  localparam logic [CFG_INDEX_W-1:0] CFG_MODE       = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_CELLS_LOW  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_CELLS_HIGH = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_CELL_LAST  = 2'd3;

  typedef struct packed {
    rc_t row;
    rc_t col;
  } pos_t;

  // One queue slot: up to two digrams produced by one input byte.
  typedef struct packed {
    logic       mode;
    logic       msg_end;
    logic [1:0] n_dg;
    code_t      d0a;
    code_t      d0b;
    code_t      d1a;
    code_t      d1b;
  } q_entry_t;

  // Token in the locate stage of the back end.
  typedef struct packed {
    logic mode;
    logic marker;
    logic last;
    logic msg_end;
    pos_t pa;
    pos_t pb;
  } s1_t;

  // Position of a letter in the square; highest matching cell wins,
  // a missing letter sits at row 0, column 0.
  function automatic pos_t locate(square_t sq, code_t code);
    pos_t p;
    p = '0;
    for (int r = 0; r < SIDE; r++) begin
      for (int c = 0; c < SIDE; c++) begin
        if (sq[r*SIDE+c] == code) begin
          p.row = rc_t'(r);
          p.col = rc_t'(c);
        end
      end
    end
    return p;
  endfunction

  function automatic code_t cell_at(square_t sq, pos_t p);
    logic [CELL_W-1:0] idx;
    idx = {p.row[2:0], 2'b00} + {2'b00, p.row} + {2'b00, p.col};
    return sq[idx];
  endfunction

  // Cyclic step by one within a row or column.
  function automatic rc_t step5(rc_t v, logic dec);
    rc_t r;
    if (dec) begin
      r = (v == '0) ? rc_t'(SIDE - 1) : v - 3'd1;
    end else begin
      r = (v == rc_t'(SIDE - 1)) ? '0 : v + 3'd1;
    end
    return r;
  endfunction

endpackage

// File: hw/rtl/pfc_if.sv
// Valid/ready channel interfaces for the input byte stream and the result letter stream.
interface pfc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;
  logic       end_of_text;

  modport source (output valid, output char_in, output end_of_text, input ready);
  modport sink   (input valid, input char_in, input end_of_text, output ready);
endinterface

interface pfc_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] letter_out;
  logic       run_end;
  logic       message_end;
  logic       no_letter;

  modport source (output valid, output letter_out, output run_end, output message_end,
                  output no_letter, input ready);
  modport sink   (input valid, input letter_out, input run_end, input message_end,
                  input no_letter, output ready);
endinterface

// File: hw/rtl/pfc_front.sv
// Front end: filters bytes, inserts and pads X, and groups letters into digrams.
module pfc_front (
  input  logic             clk,
  input  logic             rst_n,
  pfc_in_if.sink           in_ch,
  input  logic             mode,
  input  logic             q_full,
  output logic             q_push,
  output pfc_pkg::q_entry_t q_data
);

  pfc_pkg::code_t prev_r, prev_nxt;
  logic           prev_v_r, prev_v_nxt;
  pfc_pkg::code_t held_r, held_nxt;
  logic           held_v_r, held_v_nxt;

  logic           is_upper, is_lower, is_letter, ins_x, accept;
  logic [7:0]     raw;
  pfc_pkg::code_t code;
  pfc_pkg::code_t seq [4];
  logic [2:0]     n;

  always_comb begin
    is_upper  = (in_ch.char_in >= pfc_pkg::ASCII_UPPER_A) &&
                (in_ch.char_in <= pfc_pkg::ASCII_UPPER_Z);
    is_lower  = (in_ch.char_in >= pfc_pkg::ASCII_LOWER_A) &&
                (in_ch.char_in <= pfc_pkg::ASCII_LOWER_Z);
    is_letter = is_upper || is_lower;
    raw       = is_lower ? (in_ch.char_in - pfc_pkg::ASCII_LOWER_A)
                         : (in_ch.char_in - pfc_pkg::ASCII_UPPER_A);
    code      = (raw[4:0] == pfc_pkg::LETTER_J) ? pfc_pkg::LETTER_I : raw[4:0];
    ins_x     = is_letter && !mode && prev_v_r && (prev_r == code);

    // letter sequence: held letter, inserted X, new letter, end pad
    for (int i = 0; i < 4; i++) begin
      seq[i] = pfc_pkg::LETTER_X;
    end
    n = '0;
    if (held_v_r) begin
      seq[0] = held_r;
      n      = 3'd1;
    end
    if (ins_x) begin
      seq[n[1:0]] = pfc_pkg::LETTER_X;
      n           = n + 3'd1;
    end
    if (is_letter) begin
      seq[n[1:0]] = code;
      n           = n + 3'd1;
    end
    if (in_ch.end_of_text && n[0]) begin
      seq[n[1:0]] = pfc_pkg::LETTER_X;
      n           = n + 3'd1;
    end
  end

  assign in_ch.ready    = !q_full;
  assign accept         = in_ch.valid && in_ch.ready;

  assign q_data.mode    = mode;
  assign q_data.msg_end = in_ch.end_of_text;
  assign q_data.n_dg    = n[2:1];
  assign q_data.d0a     = seq[0];
  assign q_data.d0b     = seq[1];
  assign q_data.d1a     = seq[2];
  assign q_data.d1b     = seq[3];
  // nothing queued for a byte that yields no result
  assign q_push         = accept && ((n[2:1] != 2'd0) || in_ch.end_of_text);

  always_comb begin
    prev_nxt   = prev_r;
    prev_v_nxt = prev_v_r;
    held_nxt   = held_r;
    held_v_nxt = held_v_r;
    if (accept) begin
      if (in_ch.end_of_text) begin
        prev_nxt   = '0;
        prev_v_nxt = 1'b0;
        held_nxt   = '0;
        held_v_nxt = 1'b0;
      end else begin
        if (is_letter) begin
          prev_nxt   = code;
          prev_v_nxt = 1'b1;
        end
        held_v_nxt = n[0];
        held_nxt   = n[0] ? (n[1] ? seq[2] : seq[0]) : '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r   <= '0;
      prev_v_r <= 1'b0;
      held_r   <= '0;
      held_v_r <= 1'b0;
    end else begin
      prev_r   <= prev_nxt;
      prev_v_r <= prev_v_nxt;
      held_r   <= held_nxt;
      held_v_r <= held_v_nxt;
    end
  end

endmodule

// File: hw/rtl/pfc_queue.sv
// Small FIFO of digram work between the front and back ends.
module pfc_queue #(
  parameter int DEPTH = pfc_pkg::QUEUE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  pfc_pkg::q_entry_t push_data,
  output logic              full,
  input  logic              pop,
  output logic              head_valid,
  output pfc_pkg::q_entry_t head
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  pfc_pkg::q_entry_t mem [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              do_push, do_pop;

  assign full       = (count_r == CNT_W'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head       = mem[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// File: hw/rtl/pfc_back.sv
// Back end: issues digrams, locates letters in the square, maps them and serializes letters.
module pfc_back (
  input  logic              clk,
  input  logic              rst_n,
  input  pfc_pkg::square_t  square,
  input  logic              head_valid,
  input  pfc_pkg::q_entry_t head,
  output logic              pop,
  pfc_out_if.source         out_ch
);

  // issue
  logic           idx_r, idx_nxt;
  logic           fire, issue_last, marker;
  pfc_pkg::code_t let_a, let_b;

  // locate stage
  logic         s1_v_r, s1_v_nxt;
  pfc_pkg::s1_t s1_r, s1_nxt;
  logic         s1_ready;

  // map
  pfc_pkg::pos_t  qa, qb;
  logic           dec;

  // output stage
  logic           out_v_r, out_v_nxt;
  logic           second_r, second_nxt;
  pfc_pkg::code_t l0_r, l0_nxt, l1_r, l1_nxt;
  logic           last_r, last_nxt;
  logic           msg_end_r, msg_end_nxt;
  logic           marker_r, marker_nxt;
  logic           show_last, load_ok;

  assign marker     = (head.n_dg == 2'd0);
  assign issue_last = marker || (head.n_dg == 2'd1) || idx_r;
  assign let_a      = idx_r ? head.d1a : head.d0a;
  assign let_b      = idx_r ? head.d1b : head.d0b;
  assign fire       = head_valid && s1_ready;
  assign pop        = fire && issue_last;
  assign idx_nxt    = fire ? !issue_last : idx_r;

  assign show_last  = marker_r || second_r;
  assign load_ok    = !out_v_r || (out_ch.ready && show_last);
  assign s1_ready   = !s1_v_r || load_ok;

  always_comb begin
    s1_v_nxt = s1_v_r;
    s1_nxt   = s1_r;
    if (s1_ready) begin
      s1_v_nxt       = fire;
      s1_nxt.mode    = head.mode;
      s1_nxt.marker  = marker;
      s1_nxt.last    = issue_last;
      s1_nxt.msg_end = head.msg_end;
      s1_nxt.pa      = pfc_pkg::locate(square, let_a);
      s1_nxt.pb      = pfc_pkg::locate(square, let_b);
    end
  end

  // Playfair rules; equal letters fall into the same-row case
  always_comb begin
    dec = s1_r.mode;
    if (s1_r.pa.row == s1_r.pb.row) begin
      qa.row = s1_r.pa.row;
      qa.col = pfc_pkg::step5(s1_r.pa.col, dec);
      qb.row = s1_r.pb.row;
      qb.col = pfc_pkg::step5(s1_r.pb.col, dec);
    end else if (s1_r.pa.col == s1_r.pb.col) begin
      qa.row = pfc_pkg::step5(s1_r.pa.row, dec);
      qa.col = s1_r.pa.col;
      qb.row = pfc_pkg::step5(s1_r.pb.row, dec);
      qb.col = s1_r.pb.col;
    end else begin
      qa.row = s1_r.pa.row;
      qa.col = s1_r.pb.col;
      qb.row = s1_r.pb.row;
      qb.col = s1_r.pa.col;
    end
  end

  always_comb begin
    out_v_nxt   = out_v_r;
    second_nxt  = second_r;
    l0_nxt      = l0_r;
    l1_nxt      = l1_r;
    last_nxt    = last_r;
    msg_end_nxt = msg_end_r;
    marker_nxt  = marker_r;
    if (load_ok) begin
      out_v_nxt   = s1_v_r;
      second_nxt  = 1'b0;
      l0_nxt      = pfc_pkg::cell_at(square, qa);
      l1_nxt      = pfc_pkg::cell_at(square, qb);
      last_nxt    = s1_r.last;
      msg_end_nxt = s1_r.msg_end;
      marker_nxt  = s1_r.marker;
    end else if (out_v_r && out_ch.ready) begin
      second_nxt = 1'b1;
    end
  end

  assign out_ch.valid       = out_v_r;
  assign out_ch.no_letter   = marker_r;
  assign out_ch.letter_out  = marker_r ? 7'd0
                            : pfc_pkg::ASCII_A7 + {2'b00, (second_r ? l1_r : l0_r)};
  assign out_ch.run_end     = marker_r || (second_r && last_r);
  assign out_ch.message_end = (marker_r || (second_r && last_r)) && msg_end_r;

  always_ff @(posedge clk) begin
    s1_r      <= s1_nxt;
    l0_r      <= l0_nxt;
    l1_r      <= l1_nxt;
    last_r    <= last_nxt;
    msg_end_r <= msg_end_nxt;
    marker_r  <= marker_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r    <= 1'b0;
      s1_v_r   <= 1'b0;
      out_v_r  <= 1'b0;
      second_r <= 1'b0;
    end else begin
      idx_r    <= idx_nxt;
      s1_v_r   <= s1_v_nxt;
      out_v_r  <= out_v_nxt;
      second_r <= second_nxt;
    end
  end

endmodule

// File: hw/rtl/playfair_digram_cipher_unit.sv
// Top level of the Playfair digram cipher unit: config registers, front, queue and back end.
//
//  channel  | dir | payload                                        | transfer when
//  ---------+-----+------------------------------------------------+------------------
//  in_ch    | in  | char_in[7:0], end_of_text                      | valid && ready
//  out_ch   | out | letter_out[6:0], run_end, message_end, no_letter | valid && ready
//  cfg_*    | in  | cfg_index[1:0], cfg_wdata[59:0]                | cfg_we
//
//  Front takes one byte per cycle while the work queue has room.
//  Back emits one letter per cycle while out_ch.ready is high: two letters per digram
//  (output serializer), one result per end marker; a byte yields 0 to 4 letters or a marker.
//  A byte's first result passes through the queue, the locate stage and the output stage.
//  rst_n is synchronous; it clears message state, queue and config registers.
//  A stalled output fills the queue, then in_ch.ready drops.
module playfair_digram_cipher_unit #(
  parameter int QUEUE_DEPTH = pfc_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  pfc_in_if.sink                             in_ch,
  pfc_out_if.source                          out_ch,
  input  logic                               cfg_we,
  input  logic [pfc_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [pfc_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  // configuration registers
  logic                           mode_r, mode_nxt;
  logic [pfc_pkg::CFG_DATA_W-1:0] cells_low_r, cells_low_nxt;
  logic [pfc_pkg::CFG_DATA_W-1:0] cells_high_r, cells_high_nxt;
  pfc_pkg::code_t                 cell_last_r, cell_last_nxt;
  pfc_pkg::square_t               square;

  // front -> queue -> back
  logic              q_push, q_full, q_pop, q_head_valid;
  pfc_pkg::q_entry_t q_wdata, q_head;

  always_comb begin
    mode_nxt       = mode_r;
    cells_low_nxt  = cells_low_r;
    cells_high_nxt = cells_high_r;
    cell_last_nxt  = cell_last_r;
    if (cfg_we) begin
      case (cfg_index)
        pfc_pkg::CFG_MODE:       mode_nxt       = cfg_wdata[0];
        pfc_pkg::CFG_CELLS_LOW:  cells_low_nxt  = cfg_wdata;
        pfc_pkg::CFG_CELLS_HIGH: cells_high_nxt = cfg_wdata;
        pfc_pkg::CFG_CELL_LAST:  cell_last_nxt  = cfg_wdata[pfc_pkg::CELL_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= 1'b0;
      cells_low_r  <= '0;
      cells_high_r <= '0;
      cell_last_r  <= '0;
    end else begin
      mode_r       <= mode_nxt;
      cells_low_r  <= cells_low_nxt;
      cells_high_r <= cells_high_nxt;
      cell_last_r  <= cell_last_nxt;
    end
  end

  // cell k lands at bits 5k..5k+4, row-major
  assign square = {cell_last_r, cells_high_r, cells_low_r};

  pfc_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .mode   (mode_r),
    .q_full (q_full),
    .q_push (q_push),
    .q_data (q_wdata)
  );

  pfc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_data  (q_wdata),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head       (q_head)
  );

  pfc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .square     (square),
    .head_valid (q_head_valid),
    .head       (q_head),
    .pop        (q_pop),
    .out_ch     (out_ch)
  );

  // end-marker results carry no letter and close both run and message
  a_marker_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.no_letter |->
      out_ch.run_end && out_ch.message_end && (out_ch.letter_out == 7'd0))
    else $error("end marker result malformed");

  // letters come from 5-bit cell codes
  a_letter_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.no_letter |->
      (out_ch.letter_out >= 7'd65) && (out_ch.letter_out <= 7'd96))
    else $error("letter out of cell code range");

  // mode write lands in the next cycle
  a_mode_write: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we && (cfg_index == pfc_pkg::CFG_MODE) |=> mode_r == $past(cfg_wdata[0]))
    else $error("mode register write lost");

endmodule

// File: bench/tb_playfair_digram_cipher_unit.sv
`timescale 1ns / 1ps
// Self-checking testbench for the Playfair digram cipher unit: directed and random byte streams.
module tb_playfair_digram_cipher_unit;

  localparam int CLK_PERIOD    = 10;
  localparam int RESET_CYCLES  = 9;
  localparam int CYCLE_LIMIT   = 400000;
  // Margin after the last expected result before the configuration changes.
  localparam int SETTLE_CYCLES = 8;
  localparam int REPORT_MAX    = 10;
  localparam int ALPHABET      = 26;
  localparam int LONG_HOLD     = 400;

  // One expected transfer on the result channel.
  typedef struct packed {
    logic [6:0] letter;
    logic       run_end;
    logic       message_end;
    logic       no_letter;
  } cipher_result_t;

  logic                               clk;
  logic                               rst_n;
  logic                               cfg_we;
  logic [pfc_pkg::CFG_INDEX_W-1:0]    cfg_index;
  logic [pfc_pkg::CFG_DATA_W-1:0]     cfg_wdata;

  pfc_in_if  in_ch ();
  pfc_out_if out_ch ();

  playfair_digram_cipher_unit uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Shadow of the configuration registers, updated on the same edge as the block.
  logic             key_mode;
  pfc_pkg::square_t key_sq;

  // Shadow of the message state.
  pfc_pkg::code_t   last_code;
  logic             last_code_valid;
  pfc_pkg::code_t   open_code;
  logic             open_valid;

  pfc_pkg::code_t   digram_codes [$];  // cipher letters produced by the current byte
  cipher_result_t   letters_due [$];   // expected output transfers, oldest first

  int unsigned      accepted_bytes = 0;
  int               fail_count     = 0;
  int               cycle_count    = 0;

  // Traffic shaping knobs, written only by the stimulus process.
  bit               gaps_on;
  bit               tx_idling;
  bit               rx_idling;
  int unsigned      hold_len;
  int unsigned      hold_seq;

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Cell of a letter in the square: the highest matching cell wins,
  // a letter not in the square sits at cell 0.
  function automatic int cell_index(pfc_pkg::code_t code);
    int pos;
    pos = 0;
    for (int k = 0; k < pfc_pkg::CELLS; k++) begin
      if (key_sq[k] == code) pos = k;
    end
    return pos;
  endfunction

  // Playfair substitution of one digram. Equal letters fall into the row rule.
  function automatic void substitute_pair(pfc_pkg::code_t a, pfc_pkg::code_t b);
    int pa, pb, r1, c1, r2, c2, step;
    pa   = cell_index(a);
    pb   = cell_index(b);
    r1   = pa / pfc_pkg::SIDE;
    c1   = pa % pfc_pkg::SIDE;
    r2   = pb / pfc_pkg::SIDE;
    c2   = pb % pfc_pkg::SIDE;
    // Decrypt moves left/up: one step back is four steps forward mod 5.
    step = key_mode ? pfc_pkg::SIDE - 1 : 1;
    if (r1 == r2) begin
      digram_codes.push_back(key_sq[r1 * pfc_pkg::SIDE + (c1 + step) % pfc_pkg::SIDE]);
      digram_codes.push_back(key_sq[r2 * pfc_pkg::SIDE + (c2 + step) % pfc_pkg::SIDE]);
    end else if (c1 == c2) begin
      digram_codes.push_back(key_sq[((r1 + step) % pfc_pkg::SIDE) * pfc_pkg::SIDE + c1]);
      digram_codes.push_back(key_sq[((r2 + step) % pfc_pkg::SIDE) * pfc_pkg::SIDE + c2]);
    end else begin
      digram_codes.push_back(key_sq[r1 * pfc_pkg::SIDE + c2]);
      digram_codes.push_back(key_sq[r2 * pfc_pkg::SIDE + c1]);
    end
  endfunction

  // Second letter closes the open digram, first letter opens one.
  function automatic void take_letter(pfc_pkg::code_t code);
    if (open_valid) begin
      substitute_pair(open_code, code);
      open_valid = 1'b0;
      open_code  = '0;
    end else begin
      open_code  = code;
      open_valid = 1'b1;
    end
  endfunction

  // Expected output transfers for one accepted byte.
  function automatic void encipher_byte(logic [7:0] ch, logic eot);
    pfc_pkg::code_t code;
    cipher_result_t res;
    digram_codes.delete();
    if ((ch >= pfc_pkg::ASCII_UPPER_A && ch <= pfc_pkg::ASCII_UPPER_Z) ||
        (ch >= pfc_pkg::ASCII_LOWER_A && ch <= pfc_pkg::ASCII_LOWER_Z)) begin
      code = (ch >= pfc_pkg::ASCII_LOWER_A) ? pfc_pkg::code_t'(ch - pfc_pkg::ASCII_LOWER_A)
                                            : pfc_pkg::code_t'(ch - pfc_pkg::ASCII_UPPER_A);
      if (code == pfc_pkg::LETTER_J) code = pfc_pkg::LETTER_I;
      // X between doubled letters, checked on the letter stream, encrypt only.
      if (!key_mode && last_code_valid && last_code == code) take_letter(pfc_pkg::LETTER_X);
      take_letter(code);
      last_code       = code;
      last_code_valid = 1'b1;
    end
    if (eot) begin
      if (open_valid) take_letter(pfc_pkg::LETTER_X);
      last_code       = '0;
      last_code_valid = 1'b0;
      open_code       = '0;
      open_valid      = 1'b0;
    end
    for (int k = 0; k < digram_codes.size(); k++) begin
      res.letter      = pfc_pkg::ASCII_A7 + {2'b00, digram_codes[k]};
      res.run_end     = (k == digram_codes.size() - 1);
      res.message_end = res.run_end && eot;
      res.no_letter   = 1'b0;
      letters_due.push_back(res);
    end
    // End of message with nothing to emit: bare end marker.
    if (eot && digram_codes.size() == 0) begin
      res = '{letter: '0, run_end: 1'b1, message_end: 1'b1, no_letter: 1'b1};
      letters_due.push_back(res);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Edge monitor: result check, register shadow, prediction on input transfer.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : edge_monitor
    cipher_result_t want;
    cipher_result_t seen;
    if (!rst_n) begin
      key_mode        = 1'b0;
      key_sq          = '0;
      last_code       = '0;
      last_code_valid = 1'b0;
      open_code       = '0;
      open_valid      = 1'b0;
      letters_due.delete();
    end else begin
      // Check first, so a result can never match an expectation made on this edge.
      if (out_ch.valid && out_ch.ready) begin
        seen = '{letter: out_ch.letter_out, run_end: out_ch.run_end,
                 message_end: out_ch.message_end, no_letter: out_ch.no_letter};
        if (letters_due.size() == 0) begin
          fail_count++;
          if (fail_count <= REPORT_MAX)
            $display("%0t: result with none expected: letter=%h run_end=%b msg_end=%b nl=%b",
                     $time, seen.letter, seen.run_end, seen.message_end, seen.no_letter);
        end else begin
          want = letters_due.pop_front();
          if (seen.letter !== want.letter || seen.run_end !== want.run_end ||
              seen.message_end !== want.message_end || seen.no_letter !== want.no_letter) begin
            fail_count++;
            if (fail_count <= REPORT_MAX)
              $display("%0t: mismatch exp letter=%h run_end=%b msg_end=%b nl=%b",
                       $time, want.letter, want.run_end, want.message_end, want.no_letter,
                       " got letter=%h run_end=%b msg_end=%b nl=%b",
                       seen.letter, seen.run_end, seen.message_end, seen.no_letter);
          end
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          pfc_pkg::CFG_MODE:       key_mode       = cfg_wdata[0];
          pfc_pkg::CFG_CELLS_LOW:  key_sq[11:0]   = cfg_wdata;
          pfc_pkg::CFG_CELLS_HIGH: key_sq[23:12]  = cfg_wdata;
          pfc_pkg::CFG_CELL_LAST:  key_sq[24]     = cfg_wdata[pfc_pkg::CELL_W-1:0];
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) begin
        encipher_byte(in_ch.char_in, in_ch.end_of_text);
        accepted_bytes++;
      end
    end
  end

  // Watchdog on total run length.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Result sink: random stall bursts, plus a long hold on request.
  // A change of hold_seq starts a hold, its length given by hold_len.
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    int          stall_left;
    int          hold_left;
    int unsigned hold_seen;
    stall_left   = 0;
    hold_left    = 0;
    hold_seen    = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_seq != hold_seen) begin
        hold_seen = hold_seq;
        hold_left = hold_len;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready = 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ch.ready = 1'b0;
      end else if (rx_idling && $urandom_range(0, 9) == 0) begin
        stall_left   = $urandom_range(0, 12);  // random stall burst length
        out_ch.ready = 1'b0;
      end else begin
        out_ch.ready = 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers. All of them are entered and left at a falling edge.
  // ---------------------------------------------------------------------------

  // One byte transfer; valid stays up afterwards so back-to-back bytes flow.
  task automatic send_byte(input logic [7:0] ch, input logic eot);
    int unsigned target;
    if (tx_idling && $urandom_range(0, 3) == 0) begin
      in_ch.valid = 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk);
    end
    target            = accepted_bytes + 1;
    in_ch.char_in     = ch;
    in_ch.end_of_text = eot;
    in_ch.valid       = 1'b1;
    do @(negedge clk); while (accepted_bytes != target);
  endtask

  task automatic send_text(input string s, input bit eot_last);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], eot_last && i == s.len() - 1);
  endtask

  // Stop sending, wait for every expected letter, then let the pipe go quiet.
  task automatic wait_drain();
    in_ch.valid = 1'b0;
    while (letters_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [pfc_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [pfc_pkg::CFG_DATA_W-1:0] data);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = data;
    @(negedge clk);
    cfg_we    = 1'b0;
  endtask

  task automatic load_square(input pfc_pkg::square_t sq);
    write_reg(pfc_pkg::CFG_CELLS_LOW, sq[11:0]);
    write_reg(pfc_pkg::CFG_CELLS_HIGH, sq[23:12]);
    write_reg(pfc_pkg::CFG_CELL_LAST, pfc_pkg::CFG_DATA_W'(sq[24]));
  endtask

  task automatic set_mode(input logic decrypt);
    write_reg(pfc_pkg::CFG_MODE, pfc_pkg::CFG_DATA_W'(decrypt));
  endtask

  function automatic pfc_pkg::square_t square_of(string s);
    pfc_pkg::square_t sq;
    for (int k = 0; k < pfc_pkg::CELLS; k++)
      sq[k] = pfc_pkg::code_t'(s[k] - pfc_pkg::ASCII_UPPER_A);
    return sq;
  endfunction

  // Random keyed square: the 25 letters without J in random order.
  function automatic pfc_pkg::square_t shuffled_square();
    pfc_pkg::code_t   pool [pfc_pkg::CELLS];
    pfc_pkg::code_t   tmp;
    pfc_pkg::square_t sq;
    int               n, j;
    n = 0;
    for (int c = 0; c < ALPHABET; c++) begin
      if (pfc_pkg::code_t'(c) != pfc_pkg::LETTER_J) begin
        pool[n] = pfc_pkg::code_t'(c);
        n++;
      end
    end
    for (int k = pfc_pkg::CELLS - 1; k > 0; k--) begin
      j       = $urandom_range(0, k);
      tmp     = pool[k];
      pool[k] = pool[j];
      pool[j] = tmp;
    end
    for (int k = 0; k < pfc_pkg::CELLS; k++) sq[k] = pool[k];
    return sq;
  endfunction

  function automatic logic [7:0] letter_byte(pfc_pkg::code_t code, bit lower);
    return (lower ? pfc_pkg::ASCII_LOWER_A : pfc_pkg::ASCII_UPPER_A) + {3'b000, code};
  endfunction

  // Messages of random letters, biased toward doubled letters, J/I and X,
  // with some non-letter bytes; every message closes with end of text.
  task automatic random_traffic(input int n_items);
    int         sent, len, pick;
    logic [7:0] ch, prev_ch;
    sent    = 0;
    prev_ch = pfc_pkg::ASCII_UPPER_A;
    while (sent < n_items) begin
      len       = ($urandom_range(0, 7) == 0) ? 1 : $urandom_range(2, 20);
      if (len > n_items - sent) len = n_items - sent;
      tx_idling = gaps_on && $urandom_range(0, 2) != 0;
      for (int i = 0; i < len; i++) begin
        pick = $urandom_range(0, 99);
        if (pick < 58)
          ch = letter_byte(pfc_pkg::code_t'($urandom_range(0, ALPHABET - 1)),
                           1'($urandom_range(0, 1)));
        else if (pick < 74)
          ch = $urandom_range(0, 1) ? prev_ch : prev_ch ^ 8'h20;  // same letter, either case
        else if (pick < 82)
          ch = letter_byte($urandom_range(0, 1) ? pfc_pkg::LETTER_J : pfc_pkg::LETTER_I,
                           1'($urandom_range(0, 1)));
        else if (pick < 88)
          ch = letter_byte(pfc_pkg::LETTER_X, 1'($urandom_range(0, 1)));
        else
          ch = 8'($urandom_range(0, 255));
        if (pick < 88) prev_ch = ch;
        send_byte(ch, i == len - 1);
        sent++;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Registers still at reset: every cell holds A, so A sits at the last cell
  // and every other letter is missing and lands on cell 0. Ends with a bare
  // end-of-text byte after a closed digram.
  task automatic test_reset_square();
    send_text("Hi!", 1'b1);
    wait_drain();
  endtask

  // Row, column and rectangle rules, doubled letters, J folding, case,
  // non-letter bytes at the char extremes and ASCII boundaries, odd pad.
  task automatic test_encrypt_rules();
    load_square(square_of("PLAYFIREXMBCDGHKNOQSTUVWZ"));
    set_mode(1'b0);
    send_text("PLADhkEE", 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_text("jI@[`{z", 1'b1);
    wait_drain();
  endtask

  // Decrypt: no X between equal letters (row rule applies), odd pad, lone end.
  task automatic test_decrypt_rules();
    set_mode(1'b1);
    send_text("EEz.", 1'b1);
    send_byte(".", 1'b1);
    wait_drain();
  endtask

  // Mode flipped while a message is open; the previous letter seen in
  // decrypt still triggers the X once back in encrypt.
  task automatic test_mode_switch();
    send_byte("k", 1'b0);
    wait_drain();
    set_mode(1'b0);
    send_text("Kr", 1'b1);
    wait_drain();
  endtask

  task automatic test_shuffled_encrypt();
    load_square(shuffled_square());
    set_mode(1'b0);
    gaps_on   = 1'b1;
    rx_idling = 1'b1;
    random_traffic(55);
    wait_drain();
  endtask

  // Long receiver hold with the sender pushing: queue fills and input stalls.
  task automatic test_output_hold();
    set_mode(1'b1);
    gaps_on   = 1'b0;
    rx_idling = 1'b0;
    hold_len  = LONG_HOLD;
    hold_seq++;
    random_traffic(40);
    // sender pause until every expected letter has arrived
    wait_drain();
    gaps_on   = 1'b1;
    rx_idling = 1'b1;
    random_traffic(20);
    wait_drain();
  endtask

  // Raw 5-bit cell codes: duplicates, codes above Z, missing letters.
  task automatic test_raw_codes();
    pfc_pkg::square_t sq;
    for (int k = 0; k < pfc_pkg::CELLS; k++) sq[k] = pfc_pkg::code_t'($urandom_range(0, 31));
    load_square(sq);
    set_mode(1'($urandom_range(0, 1)));
    random_traffic(50);
    wait_drain();
  endtask

  // Register extremes: all-ones cell fields and Z (code 25) in the last cell.
  task automatic test_extreme_registers();
    write_reg(pfc_pkg::CFG_CELLS_LOW, '1);
    write_reg(pfc_pkg::CFG_CELLS_HIGH, '1);
    write_reg(pfc_pkg::CFG_CELL_LAST, pfc_pkg::CFG_DATA_W'(ALPHABET - 1));
    set_mode(1'b1);
    random_traffic(10);
    wait_drain();
    set_mode(1'b0);
    random_traffic(10);
    wait_drain();
  endtask

  // Closing stretch at full rate on both sides.
  task automatic test_quiet_tail();
    load_square(shuffled_square());
    set_mode(1'b0);
    gaps_on   = 1'b0;
    tx_idling = 1'b0;
    rx_idling = 1'b0;
    random_traffic(55);
    wait_drain();
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_index         = pfc_pkg::CFG_MODE;
    cfg_wdata         = '0;
    in_ch.valid       = 1'b0;
    in_ch.char_in     = '0;
    in_ch.end_of_text = 1'b0;
    gaps_on           = 1'b0;
    tx_idling         = 1'b0;
    rx_idling         = 1'b0;
    hold_len          = 0;
    hold_seq          = 0;
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n = 1'b1;

    test_reset_square();
    test_encrypt_rules();
    test_decrypt_rules();
    test_mode_switch();
    test_shuffled_encrypt();
    test_output_hold();
    test_raw_codes();
    test_extreme_registers();
    test_quiet_tail();

    if (fail_count == 0 && letters_due.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
